/* sv/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Widths, codes and types shared by the interfaces, the divider and the top
// level of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Number of slots in the free stack.
   localparam int POOL_SLOTS = 1024;
   // Index into the free stack memory.
   localparam int SLOT_IDX_W = $clog2(POOL_SLOTS);
   // Stack pointer, able to hold POOL_SLOTS itself.
   localparam int TOP_W      = $clog2(POOL_SLOTS + 1);

   // Field widths.
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int ALIGN_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int BLOCKS_W   = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Request operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BYTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_ALIGN = 3'd3;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0]  RESET_REGION_BASE  = 32'd0;
   localparam logic [ADDR_W-1:0]  RESET_REGION_BYTES = 32'd16384;
   localparam logic [SIZE_W-1:0]  RESET_OBJECT_BYTES = 16'd16;
   localparam logic [ALIGN_W-1:0] RESET_OBJECT_ALIGN = 8'd8;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Top level sequencer states.
   typedef enum logic [2:0] {
      ST_SETUP,
      ST_DIVIDE,
      ST_FILL,
      ST_READY,
      ST_POP
   } state_type;

endpackage

/* sv/fbpa_if.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator channels
// Valid/ready channels for requests, responses and configuration writes.
// ----------------------------------------------------------------------------

// Request channel: allocate or free one block.
interface fbpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [fbpa_pkg::SIZE_W-1:0]   request_bytes;
   logic [fbpa_pkg::ALIGN_W-1:0]  request_align;
   logic [fbpa_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, output op, output request_bytes,
                   output request_align, output free_address, input ready);
   modport sink   (input valid, input op, input request_bytes,
                   input request_align, input free_address, output ready);
endinterface

// Response channel: one response for every request.
interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbpa_pkg::ADDR_W-1:0]   block_address;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::ADDR_W-1:0]   used_bytes;
   logic [fbpa_pkg::BLOCKS_W-1:0] alloc_count;

   modport source (output valid, output block_address, output status,
                   output used_bytes, output alloc_count, input ready);
   modport sink   (input valid, input block_address, input status,
                   input used_bytes, input alloc_count, output ready);
endinterface

// Configuration write channel.
interface fbpa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fbpa_pkg::CSR_IDX_W-1:0]  index;
   logic [fbpa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fbpa_div.sv */
// ----------------------------------------------------------------------------
// Pool slot count divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend by a
// 16-bit divisor.
// ----------------------------------------------------------------------------
module fbpa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
   output logic                        done,
   output logic [fbpa_pkg::ADDR_W-1:0] quotient
);

   localparam int CNT_W = $clog2(fbpa_pkg::ADDR_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [fbpa_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [fbpa_pkg::ADDR_W-1:0] quo_ff, quo_in;
   logic [fbpa_pkg::SIZE_W:0]   trial;
   logic                        fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? fbpa_pkg::SIZE_W'(trial - {1'b0, divisor})
                       : trial[fbpa_pkg::SIZE_W-1:0];
         quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(fbpa_pkg::ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal-sized blocks of a memory region, keeping
// the free block addresses on a LIFO stack held in a RAM.
//
//   Channel  Dir  Handshake    Carries
//   req_bus  in   valid/ready  op, request_bytes, request_align, free_address
//   rsp_bus  out  valid/ready  block_address, status, used_bytes, alloc_count
//   csr_bus  in   valid/ready  index, data (register write)
//
// A free and any rejected request are answered from the response register;
// a successful allocate first passes the pop state, as the popped address
// comes through the stack RAM's read port. Reset and every configuration
// write to a valid index run the layout sequence, during which no request
// is taken: a setup state, the serial divider, then the stack fill, slot by slot.
// The response register lets a new request be taken in the cycle that the
// previous response is taken; a stalled response holds back requests.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
   input  logic       clock,
   input  logic       reset,
   fbpa_req_if.sink   req_bus,
   fbpa_rsp_if.source rsp_bus,
   fbpa_csr_if.sink   csr_bus
);

   localparam int SW = fbpa_pkg::SLOT_IDX_W;
   localparam int TW = fbpa_pkg::TOP_W;
   localparam int AW = fbpa_pkg::ADDR_W;
   localparam int BW = fbpa_pkg::BLOCKS_W;

   // Configuration registers.
   logic [AW-1:0]                region_base_ff, region_base_in;
   logic [AW-1:0]                region_bytes_ff, region_bytes_in;
   logic [fbpa_pkg::SIZE_W-1:0]  object_bytes_ff, object_bytes_in;
   logic [fbpa_pkg::ALIGN_W-1:0] object_align_ff, object_align_in;

   // Sequencer and pool state.
   fbpa_pkg::state_type state_ff, state_in;
   logic [TW-1:0]       top_ff, top_in;
   logic [TW-1:0]       fill_cnt_ff, fill_cnt_in;
   logic [AW-1:0]       fill_addr_ff, fill_addr_in;
   logic [AW-1:0]       bytes_ff, bytes_in;
   logic [BW-1:0]       blocks_ff, blocks_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]          rsp_addr_ff, rsp_addr_in;
   fbpa_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [AW-1:0]          rsp_used_ff, rsp_used_in;
   logic [BW-1:0]          rsp_count_ff, rsp_count_in;

   // Layout arithmetic.
   logic                         align_ok;
   logic [fbpa_pkg::ALIGN_W-1:0] align_mask;
   logic [fbpa_pkg::ALIGN_W-1:0] adjust;
   logic [AW-1:0]                first_addr;
   logic                         no_slots;
   logic [AW-1:0]                dividend;
   logic                         div_start;
   logic                         div_done;
   logic [AW-1:0]                quotient;
   logic [TW-1:0]                slot_count;

   // Request handling.
   logic          csr_write;
   logic          req_fire;
   logic          mismatch;
   logic          alloc_ok;
   logic [TW-1:0] top_dec;
   logic [TW-1:0] fill_dec;
   logic [AW-1:0] obj_bytes_ext;

   // Stack RAM ports.
   logic          ram_wr_en;
   logic [SW-1:0] ram_wr_addr;
   logic [AW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [SW-1:0] ram_rd_addr;
   logic [AW-1:0] ram_rd_data;

   // Configuration writes are always taken; a valid index reruns the layout.
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && (csr_bus.index <= fbpa_pkg::CSR_OBJECT_ALIGN);

   always_comb begin
      region_base_in  = region_base_ff;
      region_bytes_in = region_bytes_ff;
      object_bytes_in = object_bytes_ff;
      object_align_in = object_align_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            fbpa_pkg::CSR_REGION_BASE:  region_base_in  = csr_bus.data;
            fbpa_pkg::CSR_REGION_BYTES: region_bytes_in = csr_bus.data;
            fbpa_pkg::CSR_OBJECT_BYTES:
               object_bytes_in = csr_bus.data[fbpa_pkg::SIZE_W-1:0];
            fbpa_pkg::CSR_OBJECT_ALIGN:
               object_align_in = csr_bus.data[fbpa_pkg::ALIGN_W-1:0];
            default: ;
         endcase
      end
   end

   // First block address and the dividend for the slot count. A zero or
   // non-power-of-two alignment lays the pool out with alignment one.
   assign align_ok   = (object_align_ff != '0) &&
                       ((object_align_ff & (object_align_ff - 1'b1)) == '0);
   assign align_mask = align_ok ? (object_align_ff - 1'b1) : '0;
   assign adjust     = ((align_mask + 1'b1) -
                        (region_base_ff[fbpa_pkg::ALIGN_W-1:0] & align_mask)) & align_mask;
   assign first_addr = region_base_ff + AW'(adjust);
   assign no_slots   = (object_bytes_ff == '0) || (region_bytes_ff < AW'(adjust));
   assign dividend   = region_bytes_ff - AW'(adjust);

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (object_bytes_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Slot count clamped to the stack depth.
   assign slot_count = (quotient > AW'(fbpa_pkg::POOL_SLOTS)) ? TW'(fbpa_pkg::POOL_SLOTS)
                                                              : quotient[TW-1:0];

   // Request decode.
   assign req_bus.ready = (state_ff == fbpa_pkg::ST_READY) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign mismatch      = (req_bus.request_bytes != object_bytes_ff) ||
                          (req_bus.request_align != object_align_ff);
   assign alloc_ok      = req_fire && (req_bus.op == fbpa_pkg::OP_ALLOC) && !mismatch &&
                          (top_ff != '0);
   assign top_dec       = top_ff - 1'b1;
   assign fill_dec      = fill_cnt_ff - 1'b1;
   assign obj_bytes_ext = AW'(object_bytes_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbpa_pkg::ST_SETUP:  state_in = no_slots ? fbpa_pkg::ST_READY : fbpa_pkg::ST_DIVIDE;
         fbpa_pkg::ST_DIVIDE: if (div_done) state_in = fbpa_pkg::ST_FILL;
         fbpa_pkg::ST_FILL:   if (fill_cnt_ff == '0) state_in = fbpa_pkg::ST_READY;
         fbpa_pkg::ST_READY:  if (alloc_ok) state_in = fbpa_pkg::ST_POP;
         fbpa_pkg::ST_POP:    state_in = fbpa_pkg::ST_READY;
         default:             state_in = fbpa_pkg::ST_SETUP;
      endcase
      if (csr_write) begin
         state_in = fbpa_pkg::ST_SETUP;
      end
   end

   // Outputs and datapath next values.
   always_comb begin
      top_in        = top_ff;
      fill_cnt_in   = fill_cnt_ff;
      fill_addr_in  = fill_addr_ff;
      bytes_in      = bytes_ff;
      blocks_in     = blocks_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = top_ff[SW-1:0];
      ram_wr_data   = req_bus.free_address;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = top_dec[SW-1:0];
      div_start     = 1'b0;
      case (state_ff)
         // Clear the pool and start the slot count division.
         fbpa_pkg::ST_SETUP: begin
            div_start    = 1'b1;
            top_in       = '0;
            fill_cnt_in  = '0;
            fill_addr_in = first_addr;
            bytes_in     = '0;
            blocks_in    = '0;
         end
         fbpa_pkg::ST_DIVIDE: begin
            if (div_done) begin
               top_in      = slot_count;
               fill_cnt_in = slot_count;
            end
         end
         // Fill from the top slot downwards so that the first block address ends on top.
         fbpa_pkg::ST_FILL: begin
            if (fill_cnt_ff != '0) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = fill_dec[SW-1:0];
               ram_wr_data  = fill_addr_ff;
               fill_addr_in = fill_addr_ff + obj_bytes_ext;
               fill_cnt_in  = fill_dec;
            end
         end
         fbpa_pkg::ST_READY: begin
            if (req_fire) begin
               rsp_addr_in  = '0;
               rsp_used_in  = bytes_ff;
               rsp_count_in = blocks_ff;
               if (req_bus.op == fbpa_pkg::OP_ALLOC) begin
                  if (mismatch) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_MISMATCH;
                  end else if (top_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_EMPTY;
                  end else begin
                     // Pop: the address arrives from the RAM next cycle.
                     ram_rd_en = 1'b1;
                     top_in    = top_dec;
                     bytes_in  = bytes_ff + obj_bytes_ext;
                     blocks_in = blocks_ff + 1'b1;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if (top_ff == TW'(fbpa_pkg::POOL_SLOTS)) begin
                     rsp_status_in = fbpa_pkg::STATUS_OVERFLOW;
                  end else begin
                     ram_wr_en     = 1'b1;
                     top_in        = top_ff + 1'b1;
                     bytes_in      = bytes_ff - obj_bytes_ext;
                     blocks_in     = blocks_ff - 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_OK;
                     rsp_used_in   = bytes_ff - obj_bytes_ext;
                     rsp_count_in  = blocks_ff - 1'b1;
                  end
               end
            end
         end
         // Complete the allocate with the address read from the stack.
         fbpa_pkg::ST_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = ram_rd_data;
            rsp_status_in = fbpa_pkg::STATUS_OK;
            rsp_used_in   = bytes_ff;
            rsp_count_in  = blocks_ff;
         end
         default: ;
      endcase
   end

   fbpa_ram #(
      .WIDTH (AW),
      .DEPTH (fbpa_pkg::POOL_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fbpa_pkg::ST_SETUP;
         rsp_valid_ff    <= 1'b0;
         top_ff          <= '0;
         fill_cnt_ff     <= '0;
         bytes_ff        <= '0;
         blocks_ff       <= '0;
         region_base_ff  <= fbpa_pkg::RESET_REGION_BASE;
         region_bytes_ff <= fbpa_pkg::RESET_REGION_BYTES;
         object_bytes_ff <= fbpa_pkg::RESET_OBJECT_BYTES;
         object_align_ff <= fbpa_pkg::RESET_OBJECT_ALIGN;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         top_ff          <= top_in;
         fill_cnt_ff     <= fill_cnt_in;
         bytes_ff        <= bytes_in;
         blocks_ff       <= blocks_in;
         region_base_ff  <= region_base_in;
         region_bytes_ff <= region_bytes_in;
         object_bytes_ff <= object_bytes_in;
         object_align_ff <= object_align_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      fill_addr_ff  <= fill_addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.block_address = rsp_addr_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.used_bytes    = rsp_used_ff;
   assign rsp_bus.alloc_count   = rsp_count_ff;

   // The stack pointer never passes the stack depth.
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TW'(fbpa_pkg::POOL_SLOTS))
      else $error("free stack pointer beyond stack depth");

   // A successful allocate reads the stack in the pop state, then responds.
   a_pop_response: assert property (@(posedge clock) disable iff (reset)
      (alloc_ok && !csr_write) |=> (state_ff == fbpa_pkg::ST_POP) ##1 rsp_valid_ff)
      else $error("allocate transaction did not complete through the pop state");

   // The response register is free when the popped address arrives.
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpa_pkg::ST_POP) |-> !rsp_valid_ff)
      else $error("response register busy during pop");

   // A push never lands on a full stack.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == fbpa_pkg::ST_READY) |-> (top_ff < TW'(fbpa_pkg::POOL_SLOTS)))
      else $error("push onto a full free stack");

   // A configuration write restarts the layout sequence.
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (state_ff == fbpa_pkg::ST_SETUP) && (bytes_ff == $past(bytes_in)))
      else $error("configuration write did not restart the pool layout");

endmodule
